/* src/ps2_key_release_line_editor_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the PS/2 key-release line editor.
// Both expect clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef PS2_KEY_RELEASE_LINE_EDITOR_TOP_ASSERT_SVH
`define PS2_KEY_RELEASE_LINE_EDITOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define PS2KRE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PS2KRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ps2kre_pkg.sv */
// ---------------------------------------------------------------------------
// ps2kre_pkg
// Types, codes and the set-2 letter table shared by the line editor.
// ---------------------------------------------------------------------------
package ps2kre_pkg;

	typedef struct packed {
		logic       read_valid;
		logic [7:0] scan_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [6:0]  letter;
		logic [2:0]  row;
		logic [2:0]  column;
		logic [39:0] locked_word;
		logic        rows_used_up;
	} out_item_t;

	// Key classes handed from the front to the back
	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_LETTER  = 3'd1;
	localparam logic [2:0] CMD_ERASE   = 3'd2;
	localparam logic [2:0] CMD_ENTER   = 3'd3;
	localparam logic [2:0] CMD_UNKNOWN = 3'd4;

	typedef struct packed {
		logic [2:0] kind;
		logic [6:0] letter;
	} key_cmd_t;

	// Event codes
	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_STORED    = 3'd1;
	localparam logic [2:0] EV_FULL      = 3'd2;
	localparam logic [2:0] EV_DELETED   = 3'd3;
	localparam logic [2:0] EV_LOCKED    = 3'd4;
	localparam logic [2:0] EV_EXHAUSTED = 3'd5;
	localparam logic [2:0] EV_UNKNOWN   = 3'd6;
	localparam logic [2:0] EV_EMPTY     = 3'd7;

	// Scan codes
	localparam logic [7:0] BREAK_PREFIX  = 8'hF0;
	localparam logic [7:0] KEY_BACKSPACE = 8'h66;
	localparam logic [7:0] KEY_ENTER     = 8'h5A;

	// Set-2 make code to ASCII capital, zero for anything else
	function automatic logic [6:0] code_to_letter(input logic [7:0] code);
		logic [6:0] ch;
		case (code)
			8'h1C: ch = 7'h41; 8'h32: ch = 7'h42; 8'h21: ch = 7'h43;
			8'h23: ch = 7'h44; 8'h24: ch = 7'h45; 8'h2B: ch = 7'h46;
			8'h34: ch = 7'h47; 8'h33: ch = 7'h48; 8'h43: ch = 7'h49;
			8'h3B: ch = 7'h4A; 8'h42: ch = 7'h4B; 8'h4B: ch = 7'h4C;
			8'h3A: ch = 7'h4D; 8'h31: ch = 7'h4E; 8'h44: ch = 7'h4F;
			8'h4D: ch = 7'h50; 8'h15: ch = 7'h51; 8'h2D: ch = 7'h52;
			8'h1B: ch = 7'h53; 8'h2C: ch = 7'h54; 8'h3C: ch = 7'h55;
			8'h2A: ch = 7'h56; 8'h1D: ch = 7'h57; 8'h22: ch = 7'h58;
			8'h35: ch = 7'h59; 8'h1A: ch = 7'h5A;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

/* src/ps2kre_front.sv */
// ---------------------------------------------------------------------------
// ps2kre_front
// Tracks the break prefix and classifies each read into a key command.
// ---------------------------------------------------------------------------
module ps2kre_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ps2kre_pkg::in_item_t in_item,
	output logic                 push_valid,
	input  logic                 push_ready,
	output ps2kre_pkg::key_cmd_t push_cmd
);
	import ps2kre_pkg::*;

	logic       release_pending_q;
	logic       pending_nxt;
	logic [6:0] ch;

	assign ch         = code_to_letter(in_item.scan_byte);
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		pending_nxt     = release_pending_q;
		push_cmd.kind   = CMD_NONE;
		push_cmd.letter = '0;
		if (in_item.read_valid) begin
			if (in_item.scan_byte == BREAK_PREFIX) begin
				pending_nxt = 1'b1;
			end else if (release_pending_q) begin
				pending_nxt = 1'b0;
				if (ch != 7'h00) begin
					push_cmd.kind   = CMD_LETTER;
					push_cmd.letter = ch;
				end else if (in_item.scan_byte == KEY_BACKSPACE) begin
					push_cmd.kind = CMD_ERASE;
				end else if (in_item.scan_byte == KEY_ENTER) begin
					push_cmd.kind = CMD_ENTER;
				end else begin
					push_cmd.kind = CMD_UNKNOWN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_pending_q <= 1'b0;
		end else if (in_valid && push_ready) begin
			release_pending_q <= pending_nxt;
		end
	end

endmodule

/* src/ps2kre_fifo.sv */
// ---------------------------------------------------------------------------
// ps2kre_fifo
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module ps2kre_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  ps2kre_pkg::key_cmd_t push_cmd,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output ps2kre_pkg::key_cmd_t pop_cmd
);
	import ps2kre_pkg::*;

	key_cmd_t   entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/ps2kre_back.sv */
// ---------------------------------------------------------------------------
// ps2kre_back
// Applies key commands to the current row and registers the result.
// ---------------------------------------------------------------------------
module ps2kre_back #(
	parameter int ROWS            = 6,
	parameter int LETTERS_PER_ROW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  ps2kre_pkg::key_cmd_t  pop_cmd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ps2kre_pkg::out_item_t out_item
);
	import ps2kre_pkg::*;

	localparam int RW     = $clog2(ROWS + 1);
	localparam int CW     = $clog2(LETTERS_PER_ROW + 1);
	localparam int WORD_N = (LETTERS_PER_ROW < 5) ? LETTERS_PER_ROW : 5;

	// Only the open row is kept: locked rows are never read again.
	logic [6:0]    letters_q   [LETTERS_PER_ROW];
	logic [6:0]    letters_nxt [LETTERS_PER_ROW];
	logic [RW-1:0] row_q;
	logic [RW-1:0] row_nxt;
	logic [CW-1:0] col_q;
	logic [CW-1:0] col_nxt;
	logic          exhausted;
	logic [2:0]    ev;
	logic [6:0]    let_out;
	logic [6:0]    erase_rd;
	logic [39:0]   word;
	logic          out_valid_q;
	out_item_t     out_q;
	out_item_t     out_d;
	logic          pop;

	assign exhausted = (row_q >= RW'(ROWS));
	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		row_nxt     = row_q;
		col_nxt     = col_q;
		letters_nxt = letters_q;
		ev          = EV_NONE;
		let_out     = '0;
		word        = '0;
		erase_rd    = '0;
		for (int i = 0; i < LETTERS_PER_ROW; i++) begin
			if (col_q == CW'(i + 1)) begin
				erase_rd = letters_q[i];
			end
		end
		if (pop_cmd.kind != CMD_NONE) begin
			if (exhausted) begin
				ev = EV_EXHAUSTED;
			end else begin
				case (pop_cmd.kind)
					CMD_LETTER: begin
						if (col_q < CW'(LETTERS_PER_ROW)) begin
							for (int i = 0; i < LETTERS_PER_ROW; i++) begin
								if (col_q == CW'(i)) begin
									letters_nxt[i] = pop_cmd.letter;
								end
							end
							col_nxt = col_q + CW'(1);
							let_out = pop_cmd.letter;
							ev      = EV_STORED;
						end else begin
							ev = EV_FULL;
						end
					end
					CMD_ERASE: begin
						if (col_q == '0) begin
							ev = EV_EMPTY;
						end else begin
							for (int i = 0; i < LETTERS_PER_ROW; i++) begin
								if (col_q == CW'(i + 1)) begin
									letters_nxt[i] = '0;
								end
							end
							col_nxt = col_q - CW'(1);
							let_out = erase_rd;
							ev      = EV_DELETED;
						end
					end
					CMD_ENTER: begin
						for (int k = 0; k < WORD_N; k++) begin
							word[8*k +: 8] = {1'b0, letters_q[k]};
						end
						for (int i = 0; i < LETTERS_PER_ROW; i++) begin
							letters_nxt[i] = '0;
						end
						col_nxt = '0;
						row_nxt = row_q + RW'(1);
						ev      = EV_LOCKED;
					end
					CMD_UNKNOWN: ev = EV_UNKNOWN;
					default:     ev = EV_NONE;
				endcase
			end
		end
	end

	always_comb begin
		out_d.event_res    = ev;
		out_d.letter       = let_out;
		out_d.row          = 3'(row_nxt);
		out_d.column       = 3'(col_nxt);
		out_d.locked_word  = word;
		out_d.rows_used_up = (row_nxt >= RW'(ROWS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LETTERS_PER_ROW; i++) begin
				letters_q[i] <= '0;
			end
		end else begin
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
			if (pop) begin
				row_q     <= row_nxt;
				col_q     <= col_nxt;
				letters_q <= letters_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= out_d;
		end
	end

endmodule

/* src/ps2_key_release_line_editor_top.sv */
// ---------------------------------------------------------------------------
// ps2_key_release_line_editor_top
// Path: each read is classified combinationally in the front, written into
//   the two-entry queue, then applied in the back and held in the result register.
// Throughput: one read per cycle while the queue has room and the consumer
//   takes results; one result per read. The back's row update is combinational.
// Reset: arst_n clears the break flag, row, column, letters and the queue at
//   once; no clearing pass, the block takes input right after reset.
// ---------------------------------------------------------------------------
`include "ps2_key_release_line_editor_top_assert.svh"

module ps2_key_release_line_editor_top #(
	parameter int ROWS            = 6,
	parameter int LETTERS_PER_ROW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ps2kre_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ps2kre_pkg::out_item_t out_item
);
	import ps2kre_pkg::*;

	// Front -> queue
	logic     push_valid;
	logic     push_ready;
	key_cmd_t push_cmd;

	// Queue -> back
	logic     pop_valid;
	logic     pop_ready;
	key_cmd_t pop_cmd;

	// Front: watches for the break prefix and turns each released key into
	// a command. Every read yields a command (NONE for prefix, press or an
	// empty read) so each transfer in maps to exactly one result out.
	ps2kre_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Two-entry queue lets the front keep taking reads while the result
	// register waits on the consumer.
	ps2kre_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// Back: owns row/column state and the open row's letters, and holds
	// the result register. Pops whenever that register is free or draining.
	ps2kre_back #(
		.ROWS            (ROWS),
		.LETTERS_PER_ROW (LETTERS_PER_ROW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Once rows run out, only idle, lock (the final one) or exhaustion occur.
	`PS2KRE_ASSERT_NOW(a_used_up_events, out_valid && out_item.rows_used_up, out_item.event_res == EV_NONE || out_item.event_res == EV_LOCKED || out_item.event_res == EV_EXHAUSTED, "edit event after rows used up")

	// A letter is reported only on store or delete.
	`PS2KRE_ASSERT_NOW(a_letter_event, out_valid && out_item.letter != 7'h00, out_item.event_res == EV_STORED || out_item.event_res == EV_DELETED, "letter on wrong event")

	// A locked word appears only with a lock event.
	`PS2KRE_ASSERT_NOW(a_word_event, out_valid && out_item.locked_word != 40'h0, out_item.event_res == EV_LOCKED, "locked word without lock")

	// Back-to-back: a queued command refills the result register right after a transfer.
	`PS2KRE_ASSERT_NEXT(a_refill, out_valid && out_ready && pop_valid, out_valid, "result register not refilled")

endmodule
